>>> hw/rtl/rfa_pkg.sv
package rfa_pkg;

    localparam int VALUE_W       = 32;
    localparam int AVG_W         = 48;
    localparam int CNT_W         = 6;
    localparam int SUM_W         = AVG_W + CNT_W;
    localparam int WINDOW_DEF    = 50;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [VALUE_W-1:0] CLOCK_NOMINAL = 32'd42000000;

    localparam logic OP_PERIOD    = 1'b0;
    localparam logic OP_CLOCK     = 1'b1;
    localparam logic CAUSE_WINDOW = 1'b0;
    localparam logic CAUSE_CLOCK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_CHK,
        ST_AVG,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic load_clock;
        logic start_term;
        logic acc;
        logic start_avg;
        logic save;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic avg_busy;
        logic window_full;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/reciprocal_frequency_averager_core.sv
// reciprocal frequency averager
// input channel s_valid/s_ready carries s_opcode and s_value: a period item
// (opcode 0) holds the tick count of one mains cycle, a clock item (opcode 1)
// holds the measured clock frequency in hertz
// each period adds clock / period as unsigned fixed point with FRAC_BITS
// fraction bits (zero period saturates) to a window sum; after WINDOW
// periods the truncated average goes out on m_valid/m_ready with cause 0
// a clock item stores the new clock and sends the last average with cause 1
// a term is formed by a bit-serial divider, one quotient bit per cycle over
// max(32 + FRAC_BITS, 54) quotient bits; a period item occupies the block
// until its term is added, and also through the average when it closes a
// window (the average is a reciprocal multiplication over four 16-bit slices)
// a clock item occupies the block until its result is in the output register
// one item is worked on at a time; s_ready is high only when the block is idle
// results sit in an output register, so a new item is taken while a result
// waits; if a second result is ready before the first transfer, the block
// holds it and stays busy until m_ready frees the register
// reset: clock 42000000 hz, empty window, last average zero, no result pending
module reciprocal_frequency_averager_core #(
    parameter int WINDOW    = rfa_pkg::WINDOW_DEF,
    parameter int FRAC_BITS = rfa_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [rfa_pkg::VALUE_W-1:0]  s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rfa_pkg::AVG_W-1:0]    m_mains_freq,
    output logic [rfa_pkg::VALUE_W-1:0]  m_clock_freq,
    output logic                         m_cause
);
    import rfa_pkg::*;

    cmd_t    cmd;
    status_t status;

    rfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rfa_dp #(
        .WINDOW    (WINDOW),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_value      (s_value),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mains_freq (m_mains_freq),
        .m_clock_freq (m_clock_freq),
        .m_cause      (m_cause)
    );

endmodule

>>> hw/rtl/rfa_ctrl.sv
module rfa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_opcode,
    output logic            s_ready,
    input  rfa_pkg::status_t status,
    output rfa_pkg::cmd_t    cmd
);
    import rfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == OP_CLOCK) ? ST_PUSH : ST_TERM;
                end
            end
            ST_TERM: begin
                if (!status.div_busy) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                state_next = status.window_full ? ST_AVG : ST_IDLE;
            end
            ST_AVG: begin
                if (!status.avg_busy) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd.load_clock = (state_reg == ST_IDLE) && s_valid && (s_opcode == OP_CLOCK);
        cmd.start_term = (state_reg == ST_IDLE) && s_valid && (s_opcode == OP_PERIOD);
        cmd.acc        = (state_reg == ST_TERM) && !status.div_busy;
        cmd.start_avg  = (state_reg == ST_CHK) && status.window_full;
        cmd.save       = (state_reg == ST_AVG) && !status.avg_busy;
        cmd.push       = (state_reg == ST_PUSH) && status.out_free;
    end

endmodule

>>> hw/rtl/rfa_dp.sv
module rfa_dp #(
    parameter int WINDOW    = rfa_pkg::WINDOW_DEF,
    parameter int FRAC_BITS = rfa_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rfa_pkg::VALUE_W-1:0]  s_value,
    input  rfa_pkg::cmd_t                cmd,
    output rfa_pkg::status_t             status,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rfa_pkg::AVG_W-1:0]    m_mains_freq,
    output logic [rfa_pkg::VALUE_W-1:0]  m_clock_freq,
    output logic                         m_cause
);
    import rfa_pkg::*;

    localparam int NUM_W     = VALUE_W + FRAC_BITS;
    localparam int DIV_W     = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int BIT_CNT_W = $clog2(DIV_W + 1);

    localparam int PART_W      = 16;
    localparam int PARTS       = 4;
    localparam int PART_IDX_W  = $clog2(PARTS);
    localparam int RECIP_W     = PARTS * PART_W;
    localparam int RECIP_SHIFT = SUM_W + CNT_W;
    localparam int ACC_W       = SUM_W + PART_W;
    localparam int AVG_LSB     = RECIP_SHIFT - (PARTS - 1) * PART_W;
    localparam logic [RECIP_W-1:0] RECIP =
        ((RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(WINDOW) - RECIP_W'(1)) / RECIP_W'(WINDOW);

    logic [VALUE_W-1:0]   clock_hz_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     window_sum_reg;
    logic [AVG_W-1:0]     last_avg_reg;
    logic                 cause_reg;

    logic [DIV_W-1:0]     quo_reg;
    logic [VALUE_W-1:0]   rem_reg;
    logic [VALUE_W-1:0]   dvs_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;

    logic [ACC_W-1:0]      avg_acc_reg;
    logic [PART_IDX_W-1:0] part_reg;
    logic                  avg_busy_reg;

    logic                 m_valid_reg;
    logic [AVG_W-1:0]     m_mains_reg;
    logic [VALUE_W-1:0]   m_clock_reg;
    logic                 m_cause_reg;

    logic [VALUE_W:0]     trial;
    logic                 q_bit;
    logic [VALUE_W:0]     rem_sub;
    logic [AVG_W-1:0]     term;
    logic [PART_W-1:0]    recip_part;
    logic [ACC_W-1:0]     avg_prod;

    // restoring step, one quotient bit per cycle; a zero divisor yields all ones
    always_comb begin
        trial   = {rem_reg, quo_reg[DIV_W-1]};
        q_bit   = (trial >= {1'b0, dvs_reg});
        rem_sub = trial - {1'b0, dvs_reg};
    end

    // saturate the term to the result width
    always_comb begin
        if (|quo_reg[DIV_W-1:AVG_W]) begin
            term = {AVG_W{1'b1}};
        end else begin
            term = quo_reg[AVG_W-1:0];
        end
    end

    // average by reciprocal multiplication, low slice of the constant first
    always_comb begin
        recip_part = RECIP[{part_reg, 4'b0000} +: PART_W];
        avg_prod   = ACC_W'(window_sum_reg) * ACC_W'(recip_part);
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_term) begin
            quo_reg <= DIV_W'(clock_hz_reg) << FRAC_BITS;
            dvs_reg <= s_value;
            rem_reg <= '0;
        end else if (bit_cnt_reg != '0) begin
            quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[VALUE_W-1:0] : trial[VALUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_avg) begin
            avg_acc_reg <= '0;
            part_reg    <= '0;
        end else if (avg_busy_reg) begin
            avg_acc_reg <= (avg_acc_reg >> PART_W) + avg_prod;
            part_reg    <= part_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg    <= '0;
            avg_busy_reg   <= 1'b0;
            clock_hz_reg   <= CLOCK_NOMINAL;
            count_reg      <= '0;
            window_sum_reg <= '0;
            last_avg_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.start_term) begin
                bit_cnt_reg <= BIT_CNT_W'(DIV_W);
            end else if (bit_cnt_reg != '0) begin
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
            if (cmd.start_avg) begin
                avg_busy_reg <= 1'b1;
            end else if (avg_busy_reg && (part_reg == PART_IDX_W'(PARTS - 1))) begin
                avg_busy_reg <= 1'b0;
            end
            if (cmd.load_clock) begin
                clock_hz_reg <= s_value;
            end
            if (cmd.acc) begin
                window_sum_reg <= window_sum_reg + SUM_W'(term);
                count_reg      <= count_reg + 1'b1;
            end else if (cmd.save) begin
                window_sum_reg <= '0;
                count_reg      <= '0;
                last_avg_reg   <= avg_acc_reg[AVG_LSB +: AVG_W];
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_clock) begin
            cause_reg <= CAUSE_CLOCK;
        end else if (cmd.start_term) begin
            cause_reg <= CAUSE_WINDOW;
        end
        if (cmd.push) begin
            m_mains_reg <= last_avg_reg;
            m_clock_reg <= clock_hz_reg;
            m_cause_reg <= cause_reg;
        end
    end

    always_comb begin
        status.div_busy    = (bit_cnt_reg != '0);
        status.avg_busy    = avg_busy_reg;
        status.window_full = (count_reg == CNT_W'(WINDOW));
        status.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_mains_freq = m_mains_reg;
    assign m_clock_freq = m_clock_reg;
    assign m_cause      = m_cause_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW))
        else $error("window count beyond window length");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start_term || cmd.start_avg) |-> (bit_cnt_reg == '0))
        else $error("divider restarted while busy");

    a_save_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.save |=> (window_sum_reg == '0) && (count_reg == '0))
        else $error("window not cleared after average");

endmodule

>>> tb/reciprocal_frequency_averager_core_tb.sv
`timescale 1ns / 1ps

module reciprocal_frequency_averager_core_tb;
    import rfa_pkg::*;

    localparam int WINDOW      = WINDOW_DEF;
    localparam int FRAC_BITS   = FRAC_BITS_DEF;
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [AVG_W-1:0] FULL_SCALE = {AVG_W{1'b1}};

    typedef struct {
        logic [AVG_W-1:0]   mains_freq;
        logic [VALUE_W-1:0] clock_freq;
        logic               cause;
    } report_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_opcode;
    logic [VALUE_W-1:0]  s_value;
    logic                m_valid;
    logic                m_ready;
    logic [AVG_W-1:0]    m_mains_freq;
    logic [VALUE_W-1:0]  m_clock_freq;
    logic                m_cause;

    // own copy of the averager state
    logic [VALUE_W-1:0]  clock_hz_q;
    int                  periods_in_window;
    logic [SUM_W-1:0]    term_sum;
    logic [AVG_W-1:0]    recent_average;

    report_t             pending_reports[$];
    int                  mismatch_count;
    int                  items_sent;
    int                  cycle_count;
    bit                  steady_flow;

    reciprocal_frequency_averager_core #(
        .WINDOW   (WINDOW),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mains_freq(m_mains_freq),
        .m_clock_freq(m_clock_freq),
        .m_cause     (m_cause)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (steady_flow)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // clock / period in fixed point, saturated to the result width
    function automatic logic [AVG_W-1:0] mains_term(logic [VALUE_W-1:0] clk,
                                                     logic [VALUE_W-1:0] period);
        logic [79:0] scaled;
        logic [79:0] quotient;
        if (period == '0)
            return FULL_SCALE;
        scaled   = 80'(clk) << FRAC_BITS;
        quotient = scaled / 80'(period);
        if (quotient > 80'(FULL_SCALE))
            return FULL_SCALE;
        return quotient[AVG_W-1:0];
    endfunction

    task automatic account_item(input logic op, input logic [VALUE_W-1:0] val);
        report_t r;
        if (op == OP_CLOCK) begin
            clock_hz_q   = val;
            r.mains_freq = recent_average;
            r.clock_freq = clock_hz_q;
            r.cause      = CAUSE_CLOCK;
            pending_reports.push_back(r);
        end else begin
            term_sum          = term_sum + SUM_W'(mains_term(clock_hz_q, val));
            periods_in_window = (periods_in_window + 1) % 64;
            if (periods_in_window == WINDOW) begin
                recent_average    = AVG_W'(term_sum / SUM_W'(WINDOW));
                term_sum          = '0;
                periods_in_window = 0;
                r.mains_freq      = recent_average;
                r.clock_freq      = clock_hz_q;
                r.cause           = CAUSE_WINDOW;
                pending_reports.push_back(r);
            end
        end
    endtask

    task automatic send_item(input logic op, input logic [VALUE_W-1:0] val);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= val;
        do @(posedge aclk); while (!s_ready);
        account_item(op, val);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge aclk);
    endtask

    // result side: random stalls, each transfer checked against the oldest report
    initial begin
        int      gap;
        report_t want;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            gap = draw_gap();
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_reports.size() == 0) begin
                $display("%0t unexpected result: mains_freq %0h clock_freq %0h cause %0b",
                         $time, m_mains_freq, m_clock_freq, m_cause);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_mains_freq !== want.mains_freq) begin
                    $display("%0t mains_freq mismatch: expected %0h actual %0h",
                             $time, want.mains_freq, m_mains_freq);
                    mismatch_count++;
                end
                if (m_clock_freq !== want.clock_freq) begin
                    $display("%0t clock_freq mismatch: expected %0h actual %0h",
                             $time, want.clock_freq, m_clock_freq);
                    mismatch_count++;
                end
                if (m_cause !== want.cause) begin
                    $display("%0t cause mismatch: expected %0b actual %0b",
                             $time, want.cause, m_cause);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_clock_before_window();
        send_item(OP_CLOCK, CLOCK_NOMINAL);
        send_item(OP_CLOCK, '0);
        send_item(OP_CLOCK, '1);
    endtask

    task automatic test_period_extremes();
        send_item(OP_PERIOD, '0);
        send_item(OP_PERIOD, 32'd1);
        send_item(OP_PERIOD, '1);
        send_item(OP_PERIOD, 32'd2);
        send_item(OP_PERIOD, 32'h8000_0000);
        send_item(OP_PERIOD, 32'h5555_5555);
        send_item(OP_PERIOD, 32'hAAAA_AAAA);
        send_item(OP_CLOCK, '0);
        send_item(OP_PERIOD, 32'd5);
    endtask

    task automatic test_clock_mid_window();
        send_item(OP_CLOCK, CLOCK_NOMINAL);
        send_item(OP_PERIOD, 32'd840000);
        send_item(OP_CLOCK, 32'd41998765);
        send_item(OP_PERIOD, 32'd839990);
    endtask

    // zero periods close the open window, then a whole window at full scale
    task automatic test_full_scale_window();
        while (periods_in_window != 0 || recent_average != FULL_SCALE)
            send_item(OP_PERIOD, '0);
        send_item(OP_CLOCK, CLOCK_NOMINAL);
    endtask

    task automatic test_drain_pause();
        repeat (8) send_item(OP_PERIOD, 32'd840000 + 32'($urandom_range(0, 4000)));
        send_item(OP_CLOCK, CLOCK_NOMINAL + 32'($urandom_range(0, 4000)));
        wait_for_drain();
        send_item(OP_CLOCK, CLOCK_NOMINAL);
    endtask

    task automatic test_random_traffic(input int target);
        int               kind;
        int               run_len;
        logic [VALUE_W-1:0] nominal;
        logic [VALUE_W-1:0] val;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0)
                steady_flow = ~steady_flow;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // a run of mains periods consistent with the current clock
                run_len = $urandom_range(1, 60);
                nominal = clock_hz_q / WINDOW;
                repeat (run_len) begin
                    if (nominal < 32'd128)
                        val = $urandom;
                    else
                        val = nominal - (nominal >> 7) + 32'($urandom_range(0, nominal >> 6));
                    send_item(OP_PERIOD, val);
                end
            end else if (kind < 9) begin
                if ($urandom_range(0, 4) != 0)
                    val = CLOCK_NOMINAL - 32'd2000 + 32'($urandom_range(0, 4000));
                else
                    val = $urandom;
                send_item(OP_CLOCK, val);
            end else begin
                case ($urandom_range(0, 3))
                    0: val = '0;
                    1: val = 32'($urandom_range(1, 15));
                    2: val = '1;
                    default: val = $urandom;
                endcase
                send_item($urandom_range(0, 1) ? OP_CLOCK : OP_PERIOD, val);
            end
        end
    endtask

    initial begin
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_opcode          <= OP_PERIOD;
        s_value           <= '0;
        clock_hz_q        = CLOCK_NOMINAL;
        periods_in_window = 0;
        term_sum          = '0;
        recent_average    = '0;
        mismatch_count    = 0;
        items_sent        = 0;
        cycle_count       = 0;
        steady_flow       = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_clock_before_window();
        test_period_extremes();
        test_clock_mid_window();
        test_full_scale_window();
        test_random_traffic(ITEM_TARGET / 2);
        test_drain_pause();
        test_random_traffic(ITEM_TARGET);

        wait_for_drain();
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rfa_pkg.sv
hw/rtl/rfa_ctrl.sv
hw/rtl/rfa_dp.sv
hw/rtl/reciprocal_frequency_averager_core.sv
tb/reciprocal_frequency_averager_core_tb.sv
